@@ rtl/midpoint_ellipse_rasterizer_defines.svh @@
// assertion macros used by the rasterizer checker
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MER_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rasterizer check failed");

// next-cycle implication, disabled while reset is low
`define MER_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rasterizer check failed");

`endif

@@ rtl/mer_pkg.sv @@
// shared types and constants of the midpoint ellipse rasterizer
`timescale 1ns / 1ps

package mer_pkg;

    // default pixel coordinate width
    localparam int COORD_BITS_DEF = 12;

    // item kinds carried on the input tuser
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // output tuser layout
    localparam int TUSER_BITS  = 2;
    localparam int TUSER_VALID = 0;
    localparam int TUSER_DEGEN = 1;

    // result flags handed to the output stage
    typedef struct packed {
        logic degenerate;
        logic last;
        logic valid_res;
    } t_flags;

endpackage

@@ rtl/midpoint_ellipse_rasterizer.sv @@
// top level of the two-region midpoint ellipse rasterizer
//
//  channel  dir  tdata (low bit up)                         tuser / tlast
//  s_axis   in   corner_x0, corner_y0, corner_x1, corner_y1  tuser: kind
//  m_axis   out  x_plus, x_minus, y_plus, y_minus            tuser: valid_res, degenerate
//                                                             tlast: last
//
// one item at a time; s_axis_tready is high only while the sequencer is idle
// a start, a region-one step, a region-two step and the step that crosses into region
// two each make passes through the one registered multiplier; a flat box or an advance
// with no ellipse goes straight to the output state
// a finished result waits in the output register and a new item is taken meanwhile;
// the sequencer holds its result while the output register is still full
// reset is synchronous, active low, and clears the control state only
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer #(
    parameter  int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    localparam int DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [DATA_BITS-1:0]            s_axis_tdata,  // corner_x0, corner_y0, corner_x1, corner_y1
    input  logic [0:0]                      s_axis_tuser,  // kind
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [DATA_BITS-1:0]            m_axis_tdata,  // x_plus, x_minus, y_plus, y_minus
    output logic [mer_pkg::TUSER_BITS-1:0]  m_axis_tuser,  // valid_res, degenerate
    output logic                            m_axis_tlast   // last
);

    import mer_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int OPW = 2 * C + 2;
    localparam int PW  = 2 * OPW;
    localparam int DW  = (PW > 64) ? 64 : PW;
    localparam int AW  = 3 * C + 1;
    localparam int W2  = 2 * C;

    typedef enum logic [4:0] {
        S_IDLE, S_S1, S_S2, S_S3, S_S4,
        S_R1A, S_R1B, S_R1C, S_R1D,
        S_T1, S_T2, S_T3, S_T4, S_T5, S_T6,
        S_R2A, S_R2B, S_R2C, S_OUT
    } t_state;

    typedef enum logic [1:0] {RES_ZERO, RES_DEGEN, RES_EMIT} t_res;

    t_state          r_state;
    t_res            r_res_sel;
    logic            r_active;
    logic            r_region_two;
    logic [C-1:0]    r_cx, r_cy, r_wspan, r_hspan, r_sx, r_sy;
    logic [W2-1:0]   r_w2, r_h2, r_u;
    logic [AW-1:0]   r_a, r_b;
    logic [OPW-1:0]  r_t;
    logic [DW-1:0]   r_acc, r_dec;

    logic [OPW-1:0]  mul_a, mul_b;
    logic [PW-1:0]   prod;
    logic            neg;
    logic            accept;
    logic            out_free;
    logic            out_load;
    t_flags          res_flags;
    logic [DATA_BITS-1:0] res_data;

    logic [C-1:0]    in_x0, in_y0, in_x1, in_y1;
    logic [C-1:0]    min_x, min_y, span_w, span_h;

    // input unpacking and box set-up
    assign in_x0  = s_axis_tdata[C-1:0];
    assign in_y0  = s_axis_tdata[2*C-1:C];
    assign in_x1  = s_axis_tdata[3*C-1:2*C];
    assign in_y1  = s_axis_tdata[4*C-1:3*C];
    assign min_x  = (in_x0 < in_x1) ? in_x0 : in_x1;
    assign min_y  = (in_y0 < in_y1) ? in_y0 : in_y1;
    assign span_w = (in_x0 < in_x1) ? (in_x1 - in_x0) : (in_x0 - in_x1);
    assign span_h = (in_y0 < in_y1) ? (in_y1 - in_y0) : (in_y0 - in_y1);

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign neg           = r_dec[DW-1];
    assign out_load      = (r_state == S_OUT) && out_free;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_S1: begin
                mul_a = OPW'(r_wspan);
                mul_b = OPW'(r_wspan);
            end
            S_S2: begin
                mul_a = OPW'(r_hspan);
                mul_b = OPW'(r_hspan);
            end
            S_S3: begin
                mul_a = OPW'(r_w2);
                mul_b = OPW'(r_hspan);
            end
            S_R1A, S_R2A: begin
                mul_a = OPW'(r_w2);
                mul_b = OPW'({r_sy, 1'b0} - (C + 1)'(1));
            end
            S_R1B, S_R2B: begin
                mul_a = OPW'(r_h2);
                mul_b = OPW'({1'b0, r_sx} + (C + 1)'(1));
            end
            S_T1: begin
                mul_a = OPW'({r_sx, 1'b1});
                mul_b = OPW'({r_sx, 1'b1});
            end
            S_T2: begin
                mul_a = OPW'(r_sy - C'(1));
                mul_b = OPW'(r_sy - C'(1));
            end
            S_T3: begin
                mul_a = OPW'(r_h2);
                mul_b = r_t;
            end
            S_T4: begin
                mul_a = OPW'(r_w2);
                mul_b = OPW'(r_u);
            end
            S_T5: begin
                mul_a = OPW'(r_w2);
                mul_b = OPW'(r_h2);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mer_mul #(
        .OP_BITS (OPW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_sel    <= RES_ZERO;
            r_active     <= 1'b0;
            r_region_two <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (s_axis_tuser[0] == KIND_START) begin
                            r_wspan      <= span_w;
                            r_hspan      <= span_h;
                            r_cx         <= min_x + (span_w >> 1);
                            r_cy         <= min_y + (span_h >> 1);
                            r_sx         <= '0;
                            r_sy         <= span_h >> 1;
                            r_region_two <= 1'b0;
                            if (span_h <= C'(1)) begin
                                r_active  <= 1'b0;
                                r_dec     <= '0;
                                r_res_sel <= RES_DEGEN;
                                r_state   <= S_OUT;
                            end else begin
                                r_state <= S_S1;
                            end
                        end else if (!r_active) begin
                            r_res_sel <= RES_ZERO;
                            r_state   <= S_OUT;
                        end else if (r_region_two) begin
                            r_state <= S_R2A;
                        end else begin
                            r_state <= S_R1A;
                        end
                    end
                end
                // squared spans, then the region-one start term
                S_S1: r_state <= S_S2;
                S_S2: begin
                    r_w2    <= prod[W2-1:0];
                    r_state <= S_S3;
                end
                S_S3: begin
                    r_h2    <= prod[W2-1:0];
                    r_state <= S_S4;
                end
                S_S4: begin
                    r_dec     <= (DW'(r_h2) << 2) + DW'(r_w2) - (prod[DW-1:0] << 1);
                    r_active  <= 1'b1;
                    r_res_sel <= RES_EMIT;
                    r_state   <= S_OUT;
                end
                // region one: slope test, then the decision update
                S_R1A: r_state <= S_R1B;
                S_R1B: begin
                    r_a     <= prod[AW-1:0];
                    r_state <= S_R1C;
                end
                S_R1C: begin
                    r_b <= prod[AW-1:0];
                    if ((r_sy != '0) && ({1'b0, r_a} > {prod[AW-1:0], 1'b0})) begin
                        r_state <= S_R1D;
                    end else begin
                        r_state <= S_T1;
                    end
                end
                S_R1D: begin
                    r_dec <= r_dec + (DW'(r_b) << 3) + (DW'(r_h2) << 2)
                           - (neg ? DW'(0) : ((DW'(r_a) << 2) - (DW'(r_w2) << 2)));
                    if (!neg) begin
                        r_sy <= r_sy - C'(1);
                    end
                    r_sx      <= r_sx + C'(1);
                    r_res_sel <= RES_EMIT;
                    r_state   <= S_OUT;
                end
                // region-two start term from the current step
                S_T1: r_state <= S_T2;
                S_T2: begin
                    r_t     <= prod[OPW-1:0];
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_u     <= prod[W2-1:0];
                    r_state <= S_T4;
                end
                S_T4: begin
                    r_acc   <= prod[DW-1:0];
                    r_state <= S_T5;
                end
                S_T5: begin
                    r_acc   <= r_acc + (prod[DW-1:0] << 2);
                    r_state <= S_T6;
                end
                S_T6: begin
                    r_dec        <= r_acc - prod[DW-1:0];
                    r_region_two <= 1'b1;
                    r_state      <= S_R2A;
                end
                // region two step
                S_R2A: r_state <= S_R2B;
                S_R2B: begin
                    r_a     <= prod[AW-1:0];
                    r_state <= S_R2C;
                end
                S_R2C: begin
                    r_dec <= r_dec + (neg ? (prod[DW-1:0] << 3) : DW'(0))
                           - (DW'(r_a) << 2) + (DW'(r_w2) << 3);
                    if (neg) begin
                        r_sx <= r_sx + C'(1);
                    end
                    r_sy      <= r_sy - C'(1);
                    r_res_sel <= RES_EMIT;
                    r_state   <= S_OUT;
                end
                // hand the result to the output register
                S_OUT: begin
                    if (out_free) begin
                        if ((r_res_sel == RES_EMIT) && (r_sy == '0)) begin
                            r_active <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result composition
    always_comb begin
        res_flags = '0;
        res_data  = '0;
        case (r_res_sel)
            RES_EMIT: begin
                res_flags.valid_res = 1'b1;
                res_flags.last      = (r_sy == '0);
                res_data = DATA_BITS'({r_cy - r_sy, r_cy + r_sy, r_cx - r_sx, r_cx + r_sx});
            end
            RES_DEGEN: begin
                res_flags.degenerate = 1'b1;
            end
            default: begin
                res_flags = '0;
                res_data  = '0;
            end
        endcase
    end

    mer_out #(
        .DATA_BITS (DATA_BITS)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_flags  (res_flags),
        .i_data   (res_data),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

@@ rtl/mer_mul.sv @@
// shared multiplier with a registered product
`timescale 1ns / 1ps

module mer_mul #(
    parameter int OP_BITS = 26
) (
    input  logic                   i_clk,
    input  logic [OP_BITS-1:0]     i_a,
    input  logic [OP_BITS-1:0]     i_b,
    output logic [2*OP_BITS-1:0]   o_prod
);

    logic [2*OP_BITS-1:0] r_prod;

    // one product per cycle, available the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= {{OP_BITS{1'b0}}, i_a} * {{OP_BITS{1'b0}}, i_b};
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/mer_out.sv @@
// output register holding one result item until the sink takes it
`timescale 1ns / 1ps

module mer_out #(
    parameter int DATA_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  mer_pkg::t_flags               i_flags,
    input  logic [DATA_BITS-1:0]          i_data,
    output logic                          o_free,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [DATA_BITS-1:0]          o_tdata,
    output logic [mer_pkg::TUSER_BITS-1:0] o_tuser,
    output logic                          o_tlast
);

    import mer_pkg::*;

    logic                 r_valid;
    logic [DATA_BITS-1:0] r_data;
    t_flags               r_flags;

    // occupancy of the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data  <= i_data;
            r_flags <= i_flags;
        end
    end

    assign o_free   = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_flags.last;

    // flags that say what the data is
    always_comb begin
        o_tuser              = '0;
        o_tuser[TUSER_VALID] = r_flags.valid_res;
        o_tuser[TUSER_DEGEN] = r_flags.degenerate;
    end

endmodule

@@ rtl/mer_checker.sv @@
// port-level checks of the rasterizer and their binding to the top level
`timescale 1ns / 1ps
`include "midpoint_ellipse_rasterizer_defines.svh"

module mer_checker #(
    parameter int DATA_BITS = 48
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [DATA_BITS-1:0]            m_axis_tdata,
    input logic [mer_pkg::TUSER_BITS-1:0]  m_axis_tuser,
    input logic                            m_axis_tlast
);

    import mer_pkg::*;

    // a stalled result holds its data
    `MER_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // the block is busy in the cycle after it takes an item
    `MER_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // coordinates and last are zero when the point set is not meaningful
    `MER_ASSERT_NOW(a_zero_when_invalid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[TUSER_VALID], (m_axis_tdata == '0) && !m_axis_tlast)

    // a flat box never carries a point set
    `MER_ASSERT_NOW(a_degen_excl, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[TUSER_DEGEN], !m_axis_tuser[TUSER_VALID])

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
    .DATA_BITS (DATA_BITS)
) u_mer_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/midpoint_ellipse_rasterizer_test.sv @@
// self-checking testbench of the midpoint ellipse rasterizer with its own point-set predictor
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_test;

    localparam int CB          = mer_pkg::COORD_BITS_DEF;
    localparam int DW          = ((4 * CB + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 17;
    localparam int ITEM_TARGET = 500;
    localparam logic [63:0] CMASK = (64'd1 << CB) - 64'd1;

    // one point set as it leaves the block
    typedef struct packed {
        logic          valid_res;
        logic [CB-1:0] x_plus;
        logic [CB-1:0] x_minus;
        logic [CB-1:0] y_plus;
        logic [CB-1:0] y_minus;
        logic          last;
        logic          degenerate;
    } t_point_set;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [DW-1:0]                s_axis_tdata = '0;   // corner_x0, corner_y0, corner_x1, corner_y1
    logic [0:0]                   s_axis_tuser = '0;   // kind
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [DW-1:0]                m_axis_tdata;        // x_plus, x_minus, y_plus, y_minus
    logic [mer_pkg::TUSER_BITS-1:0] m_axis_tuser;      // valid_res, degenerate
    logic                         m_axis_tlast;        // last

    // predictor state of the ellipse in progress
    bit          ell_active;
    bit          ell_second_region;
    logic [63:0] ctr_x, ctr_y, box_w, box_h, step_x, step_y, decision;

    t_point_set  expected_points[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    int          hold_asked = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    midpoint_ellipse_rasterizer #(
        .COORD_BITS (CB)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirrored points of the current step, closing the ellipse on step y zero
    function automatic t_point_set mirrored_points();
        t_point_set r;
        logic [63:0] sum;
        r = '0;
        r.valid_res = 1'b1;
        sum = ctr_x + step_x;
        r.x_plus = sum[CB-1:0];
        sum = ctr_x - step_x;
        r.x_minus = sum[CB-1:0];
        sum = ctr_y + step_y;
        r.y_plus = sum[CB-1:0];
        sum = ctr_y - step_y;
        r.y_minus = sum[CB-1:0];
        r.last = (step_y == 64'd0);
        if (step_y == 64'd0) begin
            ell_active = 1'b0;
        end
        return r;
    endfunction

    // next point set for one item, decision kept scaled by 16 modulo 2^64
    function automatic t_point_set next_point_set(input logic kind,
                                                  input logic [CB-1:0] x0, y0, x1, y1);
        t_point_set r;
        logic [63:0] w2, h2, tx, ty, lo_x, lo_y;
        logic neg;
        r = '0;
        if (kind == mer_pkg::KIND_START) begin
            lo_x = 64'((x0 < x1) ? x0 : x1);
            lo_y = 64'((y0 < y1) ? y0 : y1);
            box_w = 64'((x0 < x1) ? x1 - x0 : x0 - x1);
            box_h = 64'((y0 < y1) ? y1 - y0 : y0 - y1);
            ctr_x = (lo_x + box_w / 2) & CMASK;
            ctr_y = (lo_y + box_h / 2) & CMASK;
            step_x = 64'd0;
            step_y = box_h / 2;
            ell_second_region = 1'b0;
            // flat box: nothing drawn
            if (box_h <= 64'd1) begin
                ell_active = 1'b0;
                decision = 64'd0;
                r.degenerate = 1'b1;
                return r;
            end
            w2 = box_w * box_w;
            h2 = box_h * box_h;
            decision = 4 * h2 + w2 - 2 * w2 * box_h;
            ell_active = 1'b1;
            return mirrored_points();
        end
        // advance with no ellipse answers all zeros
        if (!ell_active) begin
            return r;
        end
        w2 = box_w * box_w;
        h2 = box_h * box_h;
        if (!ell_second_region) begin
            if (step_y != 64'd0 && w2 * (2 * step_y - 1) > 2 * h2 * (step_x + 1)) begin
                neg = decision[63];
                decision = decision + 4 * h2 * (2 * step_x + 3);
                if (!neg) begin
                    decision = decision - 4 * w2 * (2 * step_y - 2);
                    step_y = (step_y - 1) & CMASK;
                end
                step_x = (step_x + 1) & CMASK;
                return mirrored_points();
            end
            // crossing into region two
            tx = 2 * step_x + 1;
            ty = step_y - 1;
            decision = h2 * tx * tx + 4 * w2 * ty * ty - w2 * h2;
            ell_second_region = 1'b1;
        end
        if (decision[63]) begin
            decision = decision + 4 * h2 * (2 * step_x + 2);
            step_x = (step_x + 1) & CMASK;
        end
        decision = decision + 12 * w2;
        decision = decision - 8 * w2 * step_y;
        step_y = (step_y - 1) & CMASK;
        return mirrored_points();
    endfunction

    // offer one item, wait for acceptance and queue its expected point set
    task automatic send_item(input logic kind, input logic [CB-1:0] x0, y0, x1, y1);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {y1, x1, y0, x0};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        expected_points.push_back(next_point_set(kind, x0, y0, x1, y1));
        items_sent++;
    endtask

    task automatic send_advance();
        send_item(mer_pkg::KIND_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom),
                  CB'($urandom));
    endtask

    // start a box of the given spans at a random place, corners in random order
    task automatic start_box(input int span_x, input int span_y);
        int lo_x, lo_y;
        logic [CB-1:0] ax, bx, ay, by;
        lo_x = $urandom_range((1 << CB) - 1 - span_x, 0);
        lo_y = $urandom_range((1 << CB) - 1 - span_y, 0);
        ax = CB'(lo_x);
        bx = CB'(lo_x + span_x);
        ay = CB'(lo_y);
        by = CB'(lo_y + span_y);
        if ($urandom_range(1) == 0) begin
            {ax, bx} = {bx, ax};
        end
        if ($urandom_range(1) == 0) begin
            {ay, by} = {by, ay};
        end
        send_item(mer_pkg::KIND_START, ax, ay, bx, by);
    endtask

    task automatic run_to_last();
        while (ell_active) begin
            send_advance();
        end
    endtask

    // advance items with no ellipse after reset
    task automatic test_idle_advance();
        send_advance();
        send_advance();
    endtask

    // boxes of height zero and one, then an advance that finds nothing active
    task automatic test_flat_boxes();
        send_item(mer_pkg::KIND_START, 12'd0, 12'd0, 12'd4095, 12'd0);
        send_item(mer_pkg::KIND_START, 12'd4095, 12'd4095, 12'd0, 12'd4094);
        send_item(mer_pkg::KIND_START, 12'd7, 12'd100, 12'd7, 12'd101);
        send_advance();
    endtask

    // small ellipses drawn to the end, including a one-pixel-wide box
    task automatic test_small_ellipses();
        send_item(mer_pkg::KIND_START, 12'd14, 12'd24, 12'd10, 12'd20);
        run_to_last();
        send_item(mer_pkg::KIND_START, 12'd1, 12'd8, 12'd0, 12'd12);
        run_to_last();
        send_advance();
    endtask

    // full-range box abandoned twice by a new start
    task automatic test_restart();
        send_item(mer_pkg::KIND_START, 12'd0, 12'd0, 12'd4095, 12'd4095);
        repeat (3) send_advance();
        send_item(mer_pkg::KIND_START, 12'd4095, 12'd4095, 12'd0, 12'd0);
        repeat (2) send_advance();
        send_item(mer_pkg::KIND_START, 12'd3, 12'd3, 12'd0, 12'd0);
        run_to_last();
    endtask

    // output held off while items keep coming
    task automatic test_output_stall();
        hold_asked <= hold_asked + 1;
        start_box(20, 16);
        repeat (12) send_advance();
        run_to_last();
    endtask

    // both sides without gaps
    task automatic test_back_to_back();
        quiet <= 1'b1;
        repeat (3) begin
            start_box($urandom_range(24), $urandom_range(24, 2));
            run_to_last();
        end
        quiet <= 1'b0;
    endtask

    // mostly whole ellipses, with flat boxes, stray advances and abandoned large boxes
    task automatic test_random_ellipses();
        int pick, steps;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(19) == 0) begin
                    start_box($urandom_range(120), $urandom_range(120, 2));
                end else begin
                    start_box($urandom_range(32), $urandom_range(32, 2));
                end
                steps = ($urandom_range(9) == 0) ? $urandom_range(8, 1) : -1;
                while (ell_active && steps != 0) begin
                    send_advance();
                    steps--;
                end
            end else if (pick < 80) begin
                start_box($urandom_range((1 << CB) - 1), $urandom_range(1));
            end else if (pick < 90) begin
                send_advance();
            end else begin
                send_item(mer_pkg::KIND_START, CB'($urandom), CB'($urandom), CB'($urandom),
                          CB'($urandom));
                repeat ($urandom_range(8)) send_advance();
            end
        end
    endtask

    // receiver readiness: long hold on request, else random gaps
    always @(posedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input logic [CB-1:0] exp_v, act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // compare each point set with the oldest expectation
    always @(posedge i_clk) begin
        t_point_set exp_set;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_points.size() == 0) begin
                $error("point set with no expectation waiting");
                mismatches++;
            end else begin
                exp_set = expected_points.pop_front();
                check_field("valid_res", CB'(exp_set.valid_res),
                            CB'(m_axis_tuser[mer_pkg::TUSER_VALID]));
                check_field("x_plus", exp_set.x_plus, m_axis_tdata[CB-1:0]);
                check_field("x_minus", exp_set.x_minus, m_axis_tdata[2*CB-1:CB]);
                check_field("y_plus", exp_set.y_plus, m_axis_tdata[3*CB-1:2*CB]);
                check_field("y_minus", exp_set.y_minus, m_axis_tdata[4*CB-1:3*CB]);
                check_field("last", CB'(exp_set.last), CB'(m_axis_tlast));
                check_field("degenerate", CB'(exp_set.degenerate),
                            CB'(m_axis_tuser[mer_pkg::TUSER_DEGEN]));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_advance();
        test_flat_boxes();
        test_small_ellipses();
        test_restart();
        test_output_stall();
        test_back_to_back();
        test_random_ellipses();
        s_axis_tvalid <= 1'b0;
        // drain, then allow for the longest step
        while (expected_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
